// ----- design/brs_pkg.sv -----
// Shared types, constants and saturation helper for the Burgers Riemann solver pipeline.
package brs_pkg;

  // Number of quotient bits produced by the divider, one per stage.
  localparam int unsigned QUO_BITS = 31;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Per-item context that travels alongside the divider.
  typedef struct packed {
    logic               roe;
    logic [31:0]        amax;
    logic signed [32:0] diff;
    logic signed [31:0] avg;
    logic signed [31:0] jump;
  } brs_ctx_t;

  // Partial remainder, remaining numerator bits and quotient so far.
  typedef struct packed {
    logic                neg;
    logic [31:0]         rem;
    logic [QUO_BITS-1:0] num_lo;
    logic [QUO_BITS-1:0] quo;
  } brs_div_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } brs_sat_t;

  typedef struct packed {
    logic signed [31:0] wave_left;
    logic signed [31:0] wave_right;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;
    logic signed [31:0] left_fluctuation;
    logic signed [31:0] right_fluctuation;
    logic signed [31:0] returned_speed;
    logic               saturated;
  } brs_res_t;

  function automatic brs_sat_t brs_sat32(input logic signed [63:0] v);
    brs_sat_t r;
    logic     hi;
    logic     lo;
    hi = ~v[63] & (|v[62:31]);
    lo = v[63] & ~(&v[62:31]);
    r.clip = hi | lo;
    if (hi) begin
      r.val = S32_MAX;
    end else if (lo) begin
      r.val = S32_MIN;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/brs_prep.sv -----
// Front stages: state magnitudes, flux-jump product and divider set-up.
module brs_prep import brs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] left_state,
  input  logic signed [31:0] right_state,
  input  logic signed [31:0] jump,
  input  logic               mode,
  input  logic               solver_kind,
  output logic               valid_o,
  output brs_ctx_t           ctx_o,
  output brs_div_t           div_o
);

  logic signed [32:0] lx;
  logic signed [32:0] rx;
  logic signed [32:0] al;
  logic signed [32:0] ar;
  logic signed [32:0] sum_c;
  logic signed [32:0] avg_c;
  brs_ctx_t           ctx_c;

  logic               v1;
  brs_ctx_t           ctx1;
  logic signed [32:0] sum1;

  logic               v2;
  brs_ctx_t           ctx2;
  logic signed [63:0] prod2;

  logic [63:0]        mag;

  always_comb begin
    lx    = {left_state[31], left_state};
    rx    = {right_state[31], right_state};
    al    = lx[32] ? -lx : lx;
    ar    = rx[32] ? -rx : rx;
    sum_c = rx + lx;
    avg_c = sum_c >>> 1;
    ctx_c.roe  = solver_kind & mode;
    ctx_c.amax = (al > ar) ? al[31:0] : ar[31:0];
    ctx_c.diff = rx - lx;
    ctx_c.avg  = avg_c[31:0];
    ctx_c.jump = jump;
  end

  // The magnitude of right^2 - left^2 never exceeds 2^62, so 64 bits hold it exactly.
  always_comb begin
    mag = prod2[63] ? -prod2 : prod2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv) begin
      v1      <= in_valid;
      v2      <= v1;
      valid_o <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx1         <= ctx_c;
      sum1         <= sum_c;
      ctx2         <= ctx1;
      prod2        <= 64'(ctx1.diff * sum1);
      ctx_o        <= ctx2;
      div_o.neg    <= prod2[63];
      div_o.rem    <= mag[62:QUO_BITS];
      div_o.num_lo <= mag[QUO_BITS-1:0];
      div_o.quo    <= '0;
    end
  end

endmodule

// ----- design/brs_div_stage.sv -----
// One restoring-division step: a single quotient bit of the flux jump over twice amax.
module brs_div_stage import brs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     valid_i,
  input  brs_ctx_t ctx_i,
  input  brs_div_t div_i,
  output logic     valid_o,
  output brs_ctx_t ctx_o,
  output brs_div_t div_o
);

  logic [32:0] trial;
  logic [32:0] dvsr;
  logic [32:0] red;
  logic        ge;
  brs_div_t    div_c;

  // The remainder always stays below the divisor, so 32 bits are enough for it.
  always_comb begin
    trial        = {div_i.rem, div_i.num_lo[QUO_BITS-1]};
    dvsr         = {ctx_i.amax, 1'b0};
    red          = trial - dvsr;
    ge           = (trial >= dvsr);
    div_c.neg    = div_i.neg;
    div_c.rem    = ge ? red[31:0] : trial[31:0];
    div_c.num_lo = {div_i.num_lo[QUO_BITS-2:0], 1'b0};
    div_c.quo    = {div_i.quo[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (adv) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_o <= ctx_i;
      div_o <= div_c;
    end
  end

endmodule

// ----- design/brs_post.sv -----
// Back stages: waves and speeds, speed-times-wave products and fluctuation split.
module brs_post import brs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     valid_i,
  input  brs_ctx_t ctx_i,
  input  brs_div_t div_i,
  output logic     valid_o,
  output brs_res_t res_o
);

  logic signed [33:0] diffx;
  logic signed [33:0] qext;
  logic signed [33:0] lo_arg;
  logic signed [33:0] hi_arg;
  logic signed [33:0] lo_half;
  logic signed [33:0] hi_half;
  logic signed [32:0] namax;
  brs_sat_t           sat_w0;
  brs_sat_t           sat_w1;
  logic               amax_zero;

  logic               vw;
  logic               roe_w;
  logic signed [31:0] w0_w;
  logic signed [31:0] w1_w;
  logic signed [31:0] s0_w;
  logic signed [31:0] s1_w;
  logic signed [31:0] ret_w;
  logic               flag_w;

  logic               vm;
  logic               roe_m;
  logic signed [31:0] w0_m;
  logic signed [31:0] w1_m;
  logic signed [31:0] s0_m;
  logic signed [31:0] s1_m;
  logic signed [31:0] ret_m;
  logic               flag_m;
  logic signed [63:0] m0;
  logic signed [63:0] m1;

  logic signed [63:0] sh0;
  logic signed [63:0] sh1;
  brs_sat_t           sat_p0;
  brs_sat_t           sat_p1;
  brs_res_t           res_c;

  // The divider works on magnitudes; the sign of the flux jump picks which wave gets +q.
  always_comb begin
    diffx     = {ctx_i.diff[32], ctx_i.diff};
    qext      = {3'b000, div_i.quo};
    lo_arg    = div_i.neg ? (diffx + qext) : (diffx - qext);
    hi_arg    = div_i.neg ? (diffx - qext) : (diffx + qext);
    lo_half   = lo_arg >>> 1;
    hi_half   = hi_arg >>> 1;
    sat_w0    = brs_sat32(64'(lo_half));
    sat_w1    = brs_sat32(64'(hi_half));
    namax     = -$signed({1'b0, ctx_i.amax});
    amax_zero = (ctx_i.amax == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vw      <= 1'b0;
      vm      <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv) begin
      vw      <= valid_i;
      vm      <= vw;
      valid_o <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roe_w <= ctx_i.roe;
      if (ctx_i.roe) begin
        w0_w   <= ctx_i.jump;
        w1_w   <= '0;
        s0_w   <= ctx_i.avg;
        s1_w   <= '0;
        ret_w  <= ctx_i.avg;
        flag_w <= 1'b0;
      end else begin
        w0_w   <= amax_zero ? '0 : sat_w0.val;
        w1_w   <= amax_zero ? '0 : sat_w1.val;
        s0_w   <= namax[31:0];
        // Only amax of exactly 2^31 sets the top bit, and it clips to the largest value.
        s1_w   <= ctx_i.amax[31] ? S32_MAX : ctx_i.amax;
        ret_w  <= ctx_i.amax[31] ? S32_MAX : ctx_i.amax;
        flag_w <= (~amax_zero & (sat_w0.clip | sat_w1.clip)) | ctx_i.amax[31];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roe_m  <= roe_w;
      w0_m   <= w0_w;
      w1_m   <= w1_w;
      s0_m   <= s0_w;
      s1_m   <= s1_w;
      ret_m  <= ret_w;
      flag_m <= flag_w;
      m0     <= 64'(s0_w * w0_w);
      m1     <= 64'(s1_w * w1_w);
    end
  end

  // In the Lax-Friedrichs case the first speed is never positive and the second never
  // negative, so each product falls wholly on one side.
  always_comb begin
    sh0    = m0 >>> FRAC_BITS;
    sh1    = m1 >>> FRAC_BITS;
    sat_p0 = brs_sat32(sh0);
    sat_p1 = brs_sat32(sh1);
    res_c.wave_left      = w0_m;
    res_c.wave_right     = w1_m;
    res_c.speed_left     = s0_m;
    res_c.speed_right    = s1_m;
    res_c.returned_speed = ret_m;
    if (roe_m) begin
      res_c.left_fluctuation  = s0_m[31] ? sat_p0.val : '0;
      res_c.right_fluctuation = s0_m[31] ? '0 : sat_p0.val;
      res_c.saturated         = flag_m | sat_p0.clip;
    end else begin
      res_c.left_fluctuation  = sat_p0.val;
      res_c.right_fluctuation = sat_p1.val;
      res_c.saturated         = flag_m | sat_p0.clip | sat_p1.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_o <= res_c;
    end
  end

endmodule

// ----- design/burgers_riemann_solver_core.sv -----
// Top level of the Burgers Riemann solver: register, pipeline and output skid buffer.
//
//  Channel   Direction  Contents
//  s_*       in         tdata: left_state, right_state, jump; tuser: mode
//  m_*       out        tdata: waves, speeds, fluctuations, returned_speed; tuser: saturated
//  cfg_*     in         solver_kind write, taken on any clock with cfg_wen high outside reset
//
// One transaction is accepted per cycle while s_tready is high.
// The divider sets the depth: 31 stages, one quotient bit each, between 3 front and
// 3 back stages, followed by the output register.
// Reset clears all valid bits and sets solver_kind to Lax-Friedrichs.
// While the output is stalled one further result is caught in the skid register;
// only once that is full does the pipeline hold and s_tready fall.
module burgers_riemann_solver_core import brs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // left_state, right_state, jump
  input  logic [0:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [223:0] m_tdata,   // wave_left, wave_right, speed_left, speed_right,
                                  // left_fluctuation, right_fluctuation, returned_speed
  output logic [0:0]   m_tuser,   // saturated
  input  logic         cfg_wen,
  input  logic [0:0]   cfg_wdata
);

  logic       solver_kind;
  logic       adv;

  logic       stage_v   [0:QUO_BITS];
  brs_ctx_t   stage_ctx [0:QUO_BITS];
  brs_div_t   stage_div [0:QUO_BITS];

  logic       pipe_v;
  brs_res_t   pipe_res;

  logic       out_valid;
  logic       out_valid_next;
  brs_res_t   out_res;
  logic       skid_valid;
  logic       skid_valid_next;
  brs_res_t   skid_res;

  logic       take;
  logic       from_pipe;
  logic       out_load;
  logic       skid_load;
  logic       out_from_skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      solver_kind <= 1'b0;
    end else if (cfg_wen) begin
      solver_kind <= cfg_wdata[0];
    end
  end

  assign adv      = ~skid_valid;
  assign s_tready = adv;

  brs_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (s_tvalid),
    .left_state  (s_tdata[31:0]),
    .right_state (s_tdata[63:32]),
    .jump        (s_tdata[95:64]),
    .mode        (s_tuser[0]),
    .solver_kind (solver_kind),
    .valid_o     (stage_v[0]),
    .ctx_o       (stage_ctx[0]),
    .div_o       (stage_div[0])
  );

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
    brs_div_stage u_step (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .valid_i (stage_v[k]),
      .ctx_i   (stage_ctx[k]),
      .div_i   (stage_div[k]),
      .valid_o (stage_v[k+1]),
      .ctx_o   (stage_ctx[k+1]),
      .div_o   (stage_div[k+1])
    );
  end

  brs_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .valid_i (stage_v[QUO_BITS]),
    .ctx_i   (stage_ctx[QUO_BITS]),
    .div_i   (stage_div[QUO_BITS]),
    .valid_o (pipe_v),
    .res_o   (pipe_res)
  );

  always_comb begin
    take            = out_valid & m_tready;
    from_pipe       = pipe_v & adv;
    out_load        = from_pipe & (~out_valid | take);
    skid_load       = from_pipe & out_valid & ~take;
    out_from_skid   = take & skid_valid;
    out_valid_next  = out_load | out_from_skid | (out_valid & ~take);
    skid_valid_next = skid_load | (skid_valid & ~out_from_skid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_res <= skid_res;
    end else if (out_load) begin
      out_res <= pipe_res;
    end
    if (skid_load) begin
      skid_res <= pipe_res;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {out_res.returned_speed, out_res.right_fluctuation,
                       out_res.left_fluctuation, out_res.speed_right, out_res.speed_left,
                       out_res.wave_right, out_res.wave_left};
  assign m_tuser[0] = out_res.saturated;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_stall_catches: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready && !skid_valid && pipe_v) |=> skid_valid)
    else $error("result leaving the pipeline during a stall was not caught");

  a_lax_speeds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.speed_right != 0) |->
      (out_res.returned_speed == out_res.speed_right && out_res.speed_left[31]))
    else $error("Lax-Friedrichs speeds are inconsistent");

  a_lax_clip_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.speed_right != 0 && out_res.speed_left == S32_MIN) |->
      out_res.saturated)
    else $error("largest amax did not raise the saturation flag");

endmodule
